/* rtl/can_frame_drive_mode_rewriter_core_assert.svh */
`ifndef CAN_FRAME_DRIVE_MODE_REWRITER_CORE_ASSERT_SVH
`define CAN_FRAME_DRIVE_MODE_REWRITER_CORE_ASSERT_SVH
// implication check under reset
`define CFD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication check under reset
`define CFD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

/* rtl/cfdmr_pkg.sv */
package cfdmr_pkg;
	localparam logic [1:0] KIND_MODE = 2'd0;
	localparam logic [1:0] KIND_BUTTON = 2'd1;
	localparam logic [1:0] KIND_FRAME = 2'd2;
	localparam logic [1:0] KIND_TICK = 2'd3;
	localparam logic [1:0] BUS_C1 = 2'd0;
	localparam logic [1:0] BUS_C2 = 2'd1;
	localparam logic [1:0] BUS_BH = 2'd2;
	localparam logic [2:0] MODE_UNKNOWN = 3'd0;
	localparam logic [2:0] MODE_RACE = 3'd1;
	localparam logic [1:0] REG_ENABLED = 2'd0;
	localparam logic [1:0] REG_LONG_PRESS = 2'd1;
	localparam logic [1:0] REG_TAP_WINDOW = 2'd2;
	localparam logic [1:0] REG_RESEND_GAP = 2'd3;
	localparam logic [28:0] ID_384 = 29'h384;
	localparam logic [28:0] ID_46C = 29'h46C;
	localparam logic [28:0] ID_4AF = 29'h4AF;
	localparam logic [28:0] ID_5A8 = 29'h5A8;
	localparam logic [28:0] ID_25A = 29'h25A;
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;

	typedef enum logic [2:0] {
		OP_NONE, OP_C1_384, OP_C2_384, OP_46C, OP_4AF, OP_5A8, OP_25A, OP_RESEND
	} op_t;

	typedef struct packed {
		logic handled;
		logic tap_twice;
		op_t op;
		logic race;
		logic [1:0] bus;
		logic [28:0] id;
		logic [3:0] dlc;
		logic [63:0] payload;
		logic [31:0] now_ms;
	} cmd_t;

	typedef struct packed {
		logic handled;
		logic tap_twice;
		logic frame_valid;
		logic [1:0] out_bus;
		logic [28:0] out_id;
		logic out_extended;
		logic [3:0] out_dlc;
		logic [63:0] out_payload;
		logic [31:0] out_timestamp;
	} res_t;

	function automatic logic [63:0] with_crc(input logic [63:0] p);
		logic [7:0] crc;
		crc = 8'hFF;
		for (int i = 0; i < 7; i++) begin
			crc = crc ^ p[8*i +: 8];
			for (int b = 0; b < 8; b++) begin
				crc = crc[7] ? ((crc << 1) ^ 8'h1D) : (crc << 1);
			end
		end
		return {crc ^ 8'hFF, p[55:0]};
	endfunction

	function automatic logic [63:0] force_mode(input logic [63:0] p, input logic [7:0] v);
		return {p[63:16], (p[15:8] & ~8'h7C) | v, p[7:0]};
	endfunction
endpackage

/* rtl/cfdmr_front.sv */
module cfdmr_front import cfdmr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data,
	input logic in_fire,
	input logic [1:0] kind,
	input logic [31:0] now_ms,
	input logic [2:0] mode,
	input logic pressed,
	input logic dyno_hold,
	input logic [1:0] bus,
	input logic [28:0] can_id,
	input logic ext_id,
	input logic [3:0] dlc,
	input logic [63:0] payload,
	input logic [15:0] rpm,
	output cmd_t cmd
);
	logic enabled_q;
	logic [15:0] long_press_q, tap_window_q, resend_gap_q;
	logic [2:0] mode_q;
	logic inv_q;
	logic [31:0] press_q, first_q, resend_q;
	logic [3:0] clicks_q;
	logic [63:0] tmpl_q;
	logic tmpl_valid_q;

	logic [2:0] mode_d;
	logic inv_d;
	logic [31:0] press_d, first_d, resend_d;
	logic [3:0] clicks_d, cc;
	logic [63:0] tmpl_d;
	logic tmpl_valid_d;
	logic [31:0] ps;
	logic race;

	assign race = (mode_q == MODE_RACE);

	always_comb begin
		mode_d = mode_q; inv_d = inv_q; press_d = press_q; first_d = first_q;
		resend_d = resend_q; clicks_d = clicks_q; tmpl_d = tmpl_q;
		tmpl_valid_d = tmpl_valid_q; ps = press_q; cc = clicks_q;
		cmd = '0;
		cmd.op = OP_NONE;
		cmd.race = race;
		cmd.bus = bus;
		cmd.id = can_id;
		cmd.dlc = dlc;
		cmd.payload = payload;
		cmd.now_ms = now_ms;
		unique case (kind)
			KIND_MODE: begin
				if (mode_q != MODE_UNKNOWN && mode_q != mode) inv_d = 1'b0;
				mode_d = mode;
			end
			KIND_BUTTON: begin
				if (pressed) begin
					if (press_q == 32'd0) begin
						ps = now_ms;
						cc = clicks_q + 4'd1;
						if (cc == 4'd1) first_d = now_ms;
					end
					press_d = ps;
					clicks_d = cc;
					if ((now_ms - ps) > {16'd0, long_press_q}) begin
						if (enabled_q && !dyno_hold) inv_d = !inv_q;
						press_d = 32'd0;
						clicks_d = 4'd0;
						cmd.handled = 1'b1;
					end
				end else begin
					press_d = 32'd0;
					if (clicks_q != 4'd0 && (now_ms - first_q) > {16'd0, tap_window_q})
						cc = 4'd0;
					clicks_d = cc;
					if (cc >= 4'd2) begin
						clicks_d = 4'd0;
						cmd.tap_twice = 1'b1;
						cmd.handled = 1'b1;
					end
				end
			end
			KIND_FRAME: begin
				if (!ext_id && bus == BUS_C1 && can_id == ID_384 && dlc == 4'd8) begin
					tmpl_d = payload;
					tmpl_valid_d = 1'b1;
				end
				if (inv_q && !ext_id) begin
					priority if (can_id == ID_384 && bus == BUS_C1 && dlc == 4'd8)
						cmd.op = OP_C1_384;
					else if (can_id == ID_384 && bus == BUS_C2 && dlc >= 4'd2)
						cmd.op = OP_C2_384;
					else if (can_id == ID_46C && bus == BUS_BH && dlc >= 4'd8 && !race)
						cmd.op = OP_46C;
					else if (can_id == ID_4AF && (bus == BUS_C1 || bus == BUS_C2)
						&& dlc >= 4'd2 && !race)
						cmd.op = OP_4AF;
					else if (can_id == ID_5A8 && bus == BUS_C1 && dlc == 4'd8)
						cmd.op = OP_5A8;
					else if (can_id == ID_25A && bus == BUS_BH && dlc >= 4'd1 && !race)
						cmd.op = OP_25A;
					else
						cmd.op = OP_NONE;
				end
			end
			KIND_TICK: begin
				if (inv_q && tmpl_valid_q) begin
					if (rpm == 16'd0) inv_d = 1'b0;
					else if (resend_q == 32'd0 ||
						(now_ms - resend_q) > {16'd0, resend_gap_q}) begin
						cmd.op = OP_RESEND;
						cmd.payload = tmpl_q;
						resend_d = now_ms;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
			long_press_q <= 16'd2000;
			tap_window_q <= 16'd1000;
			resend_gap_q <= 16'd50;
			mode_q <= MODE_UNKNOWN;
			inv_q <= 1'b0;
			press_q <= '0;
			first_q <= '0;
			resend_q <= '0;
			clicks_q <= '0;
			tmpl_q <= '0;
			tmpl_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ENABLED: enabled_q <= cfg_data[0];
					REG_LONG_PRESS: long_press_q <= cfg_data;
					REG_TAP_WINDOW: tap_window_q <= cfg_data;
					REG_RESEND_GAP: resend_gap_q <= cfg_data;
					default: ;
				endcase
			end
			if (in_fire) begin
				mode_q <= mode_d;
				inv_q <= inv_d;
				press_q <= press_d;
				first_q <= first_d;
				resend_q <= resend_d;
				clicks_q <= clicks_d;
				tmpl_q <= tmpl_d;
				tmpl_valid_q <= tmpl_valid_d;
			end
		end
	end

	`include "can_frame_drive_mode_rewriter_core_assert.svh"
	`CFD_ASSERT_NEXT(a_tmpl_sticky, tmpl_valid_q, tmpl_valid_q)
	`CFD_ASSERT_IMP(a_resend_needs_inv, cmd.op == OP_RESEND, inv_q && tmpl_valid_q)
	`CFD_ASSERT_NEXT(a_rpm_clears, in_fire && kind == KIND_TICK && rpm == 16'd0 && tmpl_valid_q, !inv_q)
endmodule

/* rtl/cfdmr_queue.sv */
module cfdmr_queue import cfdmr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input cmd_t push_data,
	output logic full,
	input logic pop,
	output logic empty,
	output cmd_t pop_data
);
	cmd_t mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0] cnt_q;

	assign full = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
		end
	end

	`include "can_frame_drive_mode_rewriter_core_assert.svh"
	`CFD_ASSERT_IMP(a_no_overflow, push, !full || pop)
	`CFD_ASSERT_IMP(a_no_underflow, pop, !empty)
	`CFD_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= (QPTR_W+1)'(QDEPTH))
endmodule

/* rtl/cfdmr_back.sv */
module cfdmr_back import cfdmr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input cmd_t cmd,
	output logic cmd_pop,
	output logic m_valid,
	input logic m_ready,
	output res_t res
);
	res_t r;
	res_t res_q;
	logic valid_q;
	logic [63:0] p, t;
	logic keep;

	always_comb begin
		p = cmd.payload;
		keep = 1'b1;
		t = p;
		unique case (cmd.op)
			OP_C1_384: t = with_crc(cmd.race ? p : force_mode(p, 8'h30));
			OP_C2_384: t = force_mode(p, cmd.race ? 8'h08 : 8'h30);
			OP_46C: t = {(p[63:56] & ~8'h1F) | 8'h0C, p[55:0]};
			OP_4AF: begin
				keep = !(p[0] && p[10]);
				t = {p[63:11], 1'b1, p[9:1], 1'b1};
			end
			OP_5A8: begin
				keep = ((p[39:32] & 8'h78) != 8'h30);
				t = with_crc({p[63:56], p[55:52], p[51:48] + 4'd1, p[47:40],
					(p[39:32] & ~8'h78) | 8'h30, p[31:0]});
			end
			OP_25A: begin
				keep = ((p[7:0] & 8'h7C) != 8'h04);
				t = {p[63:8], (p[7:0] & ~8'h7C) | 8'h04};
			end
			OP_RESEND: t = with_crc(force_mode(p, 8'h30));
			OP_NONE: keep = 1'b0;
			default: keep = 1'b0;
		endcase
		r = '0;
		r.tap_twice = cmd.tap_twice;
		r.handled = cmd.handled;
		if (keep) begin
			r.handled = 1'b1;
			r.frame_valid = 1'b1;
			r.out_bus = (cmd.op == OP_RESEND) ? BUS_C1 : cmd.bus;
			r.out_id = (cmd.op == OP_RESEND) ? ID_384 : cmd.id;
			r.out_dlc = (cmd.op == OP_RESEND) ? 4'd8 : cmd.dlc;
			r.out_payload = t;
			r.out_timestamp = cmd.now_ms;
		end
	end

	assign cmd_pop = cmd_valid && (!valid_q || m_ready);
	assign m_valid = valid_q;
	assign res = res_q;

	always_ff @(posedge clk) begin
		if (cmd_pop) res_q <= r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (cmd_pop) valid_q <= 1'b1;
		else if (m_ready) valid_q <= 1'b0;
	end

	`include "can_frame_drive_mode_rewriter_core_assert.svh"
	`CFD_ASSERT_NEXT(a_hold_stalled, valid_q && !m_ready, valid_q)
	`CFD_ASSERT_IMP(a_frame_handled, valid_q && res_q.frame_valid, res_q.handled)
endmodule

/* rtl/can_frame_drive_mode_rewriter_core.sv */
// Path from input transaction to result: front -> queue -> output register.
// Throughput: one transaction per cycle unless stalled; one result per input, in order.
// A 2-entry queue lets the front keep accepting while the output stalls.
// Reset (arst_n low, asynchronous): registers to defaults, inversion off,
// template invalid, queue and output emptied.
module can_frame_drive_mode_rewriter_core import cfdmr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data,
	input logic s_tvalid,
	output logic s_tready,
	// kind[1:0]
	input logic [1:0] s_tuser,
	// now_ms[31:0], mode[34:32], pressed[35], dyno_hold[36], bus[38:37],
	// can_id[67:39], ext_id[68], dlc[72:69], payload[136:73], rpm[152:137], 0 pad
	input logic [159:0] s_tdata,
	output logic m_tvalid,
	input logic m_tready,
	// handled[0], tap_twice[1], frame_valid[2], out_bus[4:3], out_id[33:5],
	// out_extended[34], out_dlc[38:35], out_payload[102:39], out_timestamp[134:103], 0 pad
	output logic [135:0] m_tdata
);
	cmd_t cmd_in, cmd_out;
	res_t res;
	logic full, empty, pop, fire;

	assign s_tready = !full;
	assign fire = s_tvalid && s_tready;

	cfdmr_front u_front (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_fire(fire),
		.kind(s_tuser), .now_ms(s_tdata[31:0]), .mode(s_tdata[34:32]),
		.pressed(s_tdata[35]), .dyno_hold(s_tdata[36]), .bus(s_tdata[38:37]),
		.can_id(s_tdata[67:39]), .ext_id(s_tdata[68]), .dlc(s_tdata[72:69]),
		.payload(s_tdata[136:73]), .rpm(s_tdata[152:137]),
		.cmd(cmd_in)
	);

	cfdmr_queue u_queue (
		.clk, .arst_n, .push(fire), .push_data(cmd_in), .full,
		.pop, .empty, .pop_data(cmd_out)
	);

	cfdmr_back u_back (
		.clk, .arst_n, .cmd_valid(!empty), .cmd(cmd_out), .cmd_pop(pop),
		.m_valid(m_tvalid), .m_ready(m_tready), .res
	);

	assign m_tdata = {1'b0, res.out_timestamp, res.out_payload, res.out_dlc,
		res.out_extended, res.out_id, res.out_bus, res.frame_valid,
		res.tap_twice, res.handled};
endmodule
